// File: hdl/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types and constants for the command frame deframer.
// ----------------------------------------------------------------------------
package cfd_pkg;

    localparam int HDR_LEN        = 3;
    localparam int SLOT_BITS      = 15;
    localparam int SLOTS_PER_WORD = 4;
    localparam int TABLE_WORD_W   = SLOT_BITS * SLOTS_PER_WORD;
    localparam int OUT_BYTES      = 17;

    // slot layout
    localparam int SLOT_VALID  = 0;
    localparam int SLOT_ID_LSB = 1;
    localparam int SLOT_MIN_LSB = 9;
    localparam int SLOT_PAD    = 14;

    typedef enum logic [1:0] {
        REG_VERSION  = 2'd0,
        REG_TABLE_LO = 2'd1,
        REG_TABLE_HI = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        V_DISPATCH    = 3'd0,
        V_BAD_VERSION = 3'd1,
        V_UNKNOWN_CMD = 3'd2,
        V_TOO_SHORT   = 3'd3,
        V_NOT_ACTIVE  = 3'd4,
        V_BAD_LENGTH  = 3'd5,
        V_UNFINISHED  = 3'd6
    } t_verdict;

    typedef struct packed {
        logic                        fire;
        logic                        drop_reset;
        logic                        bad_len;
        logic [7:0]                  ver;
        logic [7:0]                  cmd;
        logic [4:0]                  plen;
        logic [OUT_BYTES-1:0][7:0]   payload;
    } t_frame_evt;

    typedef struct packed {
        logic       found;
        logic [4:0] min_len;
        logic       pad;
    } t_cmd_hit;

    typedef struct packed {
        t_verdict                    verdict;
        logic [7:0]                  cmd;
        logic [4:0]                  plen;
        logic [OUT_BYTES-1:0][7:0]   payload;
        logic                        skip_inc;
        logic                        rej_inc;
        logic                        drop_inc;
    } t_judge_res;

endpackage

// File: hdl/cfd_cmd_match.sv
// ----------------------------------------------------------------------------
// cfd_cmd_match
// Parallel search of the command slots; the lowest valid matching slot wins.
// ----------------------------------------------------------------------------
module cfd_cmd_match
    import cfd_pkg::*;
#(
    parameter int COMMAND_SLOTS = 8
) (
    input  logic [TABLE_WORD_W-1:0] i_table_lo,
    input  logic [TABLE_WORD_W-1:0] i_table_hi,
    input  logic [7:0]              i_cmd,
    output t_cmd_hit                o_hit
);

    logic [2*TABLE_WORD_W-1:0] table_all;

    assign table_all = {i_table_hi, i_table_lo};

    always_comb begin
        logic [SLOT_BITS-1:0] slot;
        o_hit = '0;
        for (int s = COMMAND_SLOTS - 1; s >= 0; s--) begin
            slot = table_all[s*SLOT_BITS +: SLOT_BITS];
            if (slot[SLOT_VALID] && (slot[SLOT_ID_LSB +: 8] == i_cmd)) begin
                o_hit.found   = 1'b1;
                o_hit.min_len = slot[SLOT_MIN_LSB +: 5];
                o_hit.pad     = slot[SLOT_PAD];
            end
        end
    end

endmodule

// File: hdl/cfd_frame_asm.sv
// ----------------------------------------------------------------------------
// cfd_frame_asm
// Frame store, byte count and discard flag; flags a finished or dropped frame.
// ----------------------------------------------------------------------------
module cfd_frame_asm
    import cfd_pkg::*;
#(
    parameter int PAYLOAD_MAX = 17
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic       i_func,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_read,
    output t_frame_evt o_evt
);

    localparam int STORE_LEN = HDR_LEN + PAYLOAD_MAX;
    localparam int HW        = $clog2(STORE_LEN + 1);
    localparam int IW        = $clog2(STORE_LEN);

    logic [7:0]    r_store [STORE_LEN];
    logic [HW-1:0] r_held, n_held;
    logic          r_discarding, n_discarding;

    logic [7:0]    view [STORE_LEN];
    logic [HW-1:0] cnt;
    logic          hdr_done;
    logic          len_over;
    logic          complete;
    logic [OUT_BYTES-1:0][7:0] pay;

    always_comb begin
        for (int i = 0; i < STORE_LEN; i++) begin
            view[i] = (r_held == HW'(i)) ? i_data_byte : r_store[i];
        end
    end

    assign cnt      = r_held + HW'(1);
    assign hdr_done = cnt >= HW'(HDR_LEN);
    assign len_over = view[2] > 8'(PAYLOAD_MAX);
    assign complete = 9'(cnt) >= (9'(HDR_LEN) + {1'b0, view[2]});

    // frame event
    always_comb begin
        o_evt            = '0;
        o_evt.ver        = view[0];
        o_evt.cmd        = view[1];
        o_evt.plen       = view[2][4:0];
        o_evt.payload    = pay;
        if (i_func) begin
            o_evt.fire       = r_held != '0;
            o_evt.drop_reset = 1'b1;
        end else if (!r_discarding && hdr_done) begin
            o_evt.fire    = len_over || complete;
            o_evt.bad_len = len_over;
        end
    end

    for (genvar g = 0; g < OUT_BYTES; g++) begin : g_pay
        if (g < PAYLOAD_MAX) begin : g_on
            assign pay[g] = (8'(g) < view[2]) ? view[HDR_LEN + g] : 8'd0;
        end else begin : g_off
            assign pay[g] = 8'd0;
        end
    end

    // count and discard
    always_comb begin
        n_held       = r_held;
        n_discarding = r_discarding;
        if (i_func) begin
            n_held       = '0;
            n_discarding = 1'b0;
        end else if (r_discarding) begin
            if (i_end_of_read) begin
                n_discarding = 1'b0;
            end
        end else if (!hdr_done) begin
            n_held = cnt;
        end else if (len_over) begin
            n_held       = '0;
            n_discarding = !i_end_of_read;
        end else if (complete) begin
            n_held = '0;
        end else begin
            n_held = cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= '0;
            r_discarding <= 1'b0;
        end else if (i_take) begin
            r_held       <= n_held;
            r_discarding <= n_discarding;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && !i_func && !r_discarding && (r_held < HW'(STORE_LEN))) begin
            r_store[r_held[IW-1:0]] <= i_data_byte;
        end
    end

endmodule

// File: hdl/cfd_judge.sv
// ----------------------------------------------------------------------------
// cfd_judge
// Verdict for a flagged frame, payload gating and counter increments.
// ----------------------------------------------------------------------------
module cfd_judge
    import cfd_pkg::*;
#(
    parameter int COMMAND_SLOTS = 8
) (
    input  t_frame_evt              i_evt,
    input  logic [7:0]              i_version,
    input  logic [TABLE_WORD_W-1:0] i_table_lo,
    input  logic [TABLE_WORD_W-1:0] i_table_hi,
    input  logic                    i_sender_active,
    output t_judge_res              o_res
);

    t_cmd_hit hit;

    cfd_cmd_match #(
        .COMMAND_SLOTS(COMMAND_SLOTS)
    ) u_match (
        .i_table_lo(i_table_lo),
        .i_table_hi(i_table_hi),
        .i_cmd     (i_evt.cmd),
        .o_hit     (hit)
    );

    always_comb begin
        o_res         = '0;
        o_res.verdict = V_DISPATCH;
        o_res.cmd     = i_evt.cmd;
        o_res.plen    = i_evt.plen;
        if (i_evt.drop_reset) begin
            o_res.verdict  = V_UNFINISHED;
            o_res.cmd      = 8'd0;
            o_res.plen     = 5'd0;
            o_res.drop_inc = 1'b1;
        end else if (i_evt.bad_len) begin
            o_res.verdict  = V_BAD_LENGTH;
            o_res.plen     = 5'd0;
            o_res.drop_inc = 1'b1;
        end else if (i_evt.ver != i_version) begin
            o_res.verdict  = V_BAD_VERSION;
            o_res.skip_inc = 1'b1;
        end else if (!hit.found) begin
            o_res.verdict  = V_UNKNOWN_CMD;
            o_res.skip_inc = 1'b1;
        end else if (i_evt.plen < hit.min_len) begin
            o_res.verdict = V_TOO_SHORT;
            o_res.rej_inc = 1'b1;
        end else if (hit.pad && !i_sender_active) begin
            o_res.verdict = V_NOT_ACTIVE;
            o_res.rej_inc = 1'b1;
        end else begin
            o_res.payload = i_evt.payload;
        end
    end

endmodule

// File: hdl/command_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// command_frame_deframer_top
// Byte-stream frame deframer with command table lookup and wrapping counters.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+-----------
//  input    | i_valid / o_ready, func, byte, eor, act   | in
//  result   | o_valid / i_ready, verdict .. counters    | out
//  config   | i_cfg_valid / o_cfg_ready, index, data    | in
//
//  One word per cycle: each byte is judged in the cycle it is taken; on a
//  frame end the result register loads on that same edge, so o_valid is high
//  from it on. The input stalls only while a result waits with i_ready low.
//  Reset is synchronous; the frame store is not cleared.
//  o_cfg_ready is always high.
// ----------------------------------------------------------------------------
module command_frame_deframer_top
    import cfd_pkg::*;
#(
    parameter int PAYLOAD_MAX   = 17,
    parameter int COMMAND_SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_read,
    input  logic        i_sender_active,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_verdict,
    output logic [7:0]  o_command,
    output logic [4:0]  o_declared_len,
    output logic [63:0] o_payload_low,
    output logic [63:0] o_payload_mid,
    output logic [7:0]  o_payload_top,
    output logic [15:0] o_skipped_count,
    output logic [15:0] o_rejected_count,
    output logic [15:0] o_dropped_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [59:0] i_cfg_data
);

    logic [7:0]              r_version;
    logic [TABLE_WORD_W-1:0] r_table_lo;
    logic [TABLE_WORD_W-1:0] r_table_hi;
    logic [15:0]             r_skipped, n_skipped;
    logic [15:0]             r_rejected, n_rejected;
    logic [15:0]             r_dropped, n_dropped;
    logic                    r_out_valid;
    t_judge_res              r_res;

    logic       accept;
    t_frame_evt evt;
    t_judge_res res;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !r_out_valid || i_ready;
    assign accept      = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version  <= 8'd1;
            r_table_lo <= '0;
            r_table_hi <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_VERSION:  r_version  <= i_cfg_data[7:0];
                REG_TABLE_LO: r_table_lo <= i_cfg_data;
                REG_TABLE_HI: r_table_hi <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    cfd_frame_asm #(
        .PAYLOAD_MAX(PAYLOAD_MAX)
    ) u_asm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (accept),
        .i_func       (i_func),
        .i_data_byte  (i_data_byte),
        .i_end_of_read(i_end_of_read),
        .o_evt        (evt)
    );

    cfd_judge #(
        .COMMAND_SLOTS(COMMAND_SLOTS)
    ) u_judge (
        .i_evt          (evt),
        .i_version      (r_version),
        .i_table_lo     (r_table_lo),
        .i_table_hi     (r_table_hi),
        .i_sender_active(i_sender_active),
        .o_res          (res)
    );

    assign n_skipped  = r_skipped + 16'(res.skip_inc);
    assign n_rejected = r_rejected + 16'(res.rej_inc);
    assign n_dropped  = r_dropped + 16'(res.drop_inc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skipped   <= '0;
            r_rejected  <= '0;
            r_dropped   <= '0;
        end else begin
            if (accept && evt.fire) begin
                r_out_valid <= 1'b1;
                r_skipped   <= n_skipped;
                r_rejected  <= n_rejected;
                r_dropped   <= n_dropped;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && evt.fire) begin
            r_res <= res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_verdict        = r_res.verdict;
    assign o_command        = r_res.cmd;
    assign o_declared_len   = r_res.plen;
    assign o_payload_low    = r_res.payload[7:0];
    assign o_payload_mid    = r_res.payload[15:8];
    assign o_payload_top    = r_res.payload[16];
    assign o_skipped_count  = r_skipped;
    assign o_rejected_count = r_rejected;
    assign o_dropped_count  = r_dropped;

    a_fire_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && evt.fire) |=> r_out_valid)
        else $error("result not loaded");

    a_idle_counters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !evt.fire) |=> ($stable(r_skipped) && $stable(r_rejected)
                                   && $stable(r_dropped)))
        else $error("counter moved without a result");

    a_drop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && evt.fire && res.drop_inc) |=> (r_dropped == $past(r_dropped) + 16'd1))
        else $error("dropped count not advanced");

    a_payload_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res.verdict != V_DISPATCH)) |-> (r_res.payload == '0))
        else $error("payload leaked on a non-dispatch verdict");

endmodule
